// ----- src/grdda_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// grdda_pkg: shared types and constants of the grid ray caster
// Holds the fixed field widths and the controller/datapath command and
// status structs.
// ----------------------------------------------------------------------------
package grdda_pkg;

    localparam int DEF_MAP_SIZE  = 64;
    localparam int DEF_FRAC_BITS = 16;

    localparam int POS_W    = 22;
    localparam int DIR_W    = 19;
    localparam int DIST_W   = 31;
    localparam int WIDTH_W  = 13;
    localparam int HEIGHT_W = 16;
    localparam int CELL_W   = 6;

    localparam logic [12:0] WIDTH_RESET = 13'd640;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CAST  = 1'b1;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;       // capture the input beat
        logic clr_start;  // start map clearing sweep
        logic step;       // advance one DDA move
        logic div_start;  // start perpendicular division
        logic mul_start;  // start coordinate multiply
        logic hgt_start;  // start column height division
        logic wr_map;     // write map cell
        logic out_load;   // capture result
        logic out_nowall; // result is the no-wall case
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic clr_busy;
        logic in_map;     // current cell inside map
        logic wall;       // registered read says wall
        logic step_done;  // move budget spent
        logic div_busy;
    } t_stat;

endpackage : grdda_pkg
`default_nettype wire

// ----- src/grdda_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// grdda_divider: restoring divider, one quotient bit per cycle
// Computes floor(num / den) on unsigned operands.
// ----------------------------------------------------------------------------
module grdda_divider
    import grdda_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 31
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic      [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;

    assign w_trial = {r_rem[DEN_W-1:0], r_quot[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!w_diff[DEN_W]) begin
                r_rem  <= w_diff;
                r_quot <= {r_quot[NUM_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_trial;
                r_quot <= {r_quot[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
endmodule : grdda_divider
`default_nettype wire

// ----- src/grdda_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// grdda_datapath: map memory, DDA stepper and result arithmetic
// Holds the wall map, walks the ray one cell per move, and computes the
// distance, hit coordinate and column height with a shared divider.
// ----------------------------------------------------------------------------
module grdda_datapath
    import grdda_pkg::*;
#(
    parameter int MAP_SIZE  = DEF_MAP_SIZE,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    input  wire logic [WIDTH_W-1:0]  i_window_width,
    input  wire logic                i_cell_wall,
    input  wire logic [POS_W-1:0]    i_pos_x,
    input  wire logic [POS_W-1:0]    i_pos_y,
    input  wire logic signed [DIR_W-1:0] i_ray_dir_x,
    input  wire logic signed [DIR_W-1:0] i_ray_dir_y,
    input  wire logic [DIST_W-1:0]   i_side_dist_x,
    input  wire logic [DIST_W-1:0]   i_side_dist_y,
    input  wire logic [DIST_W-1:0]   i_delta_dist_x,
    input  wire logic [DIST_W-1:0]   i_delta_dist_y,
    output logic                     o_hit_side,
    output logic [CELL_W-1:0]        o_hit_col,
    output logic [CELL_W-1:0]        o_hit_row,
    output logic [DIST_W-1:0]        o_perp_dist,
    output logic [POS_W-1:0]         o_hit_coord,
    output logic [HEIGHT_W-1:0]      o_column_height
);
    localparam int IDX_W   = $clog2(MAP_SIZE);
    localparam int DEPTH   = MAP_SIZE * MAP_SIZE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int INT_W   = POS_W - FRAC_BITS;
    localparam int CW      = INT_W + 2;                  // signed cell coord
    localparam int MOVES   = 2 * MAP_SIZE + 2;
    localparam int MV_W    = $clog2(MOVES + 1);
    localparam int SD_W    = DIST_W + MV_W;              // side distance sums
    localparam int DNUM_W  = POS_W + 2 + FRAC_BITS;      // dividend width
    localparam int PROD_W  = DIST_W + DIR_W;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Map memory, cleared by a sweep after reset.
    logic             r_map [DEPTH];
    logic [ADDR_W:0]  r_clr_cnt;
    logic             r_clr_busy;
    logic             r_rd;

    // Captured item.
    logic [POS_W-1:0]        r_px, r_py;
    logic signed [DIR_W-1:0] r_dx, r_dy;
    logic [SD_W-1:0]         r_sdx, r_sdy;
    logic [DIST_W-1:0]       r_ddx, r_ddy;
    logic signed [CW-1:0]    r_cx, r_cy;
    logic                    r_side;
    logic                    r_wall_bit;
    logic [MV_W-1:0]         r_moves;
    logic [DIST_W-1:0]       r_perp;

    logic signed [CW-1:0] w_ncx, w_ncy;
    logic                 w_out;
    logic [ADDR_W-1:0]    w_addr;

    assign w_out = (r_cx < 0) || (r_cy < 0) ||
                   (r_cx >= CW'(MAP_SIZE)) || (r_cy >= CW'(MAP_SIZE));
    assign w_addr = {r_cy[IDX_W-1:0], r_cx[IDX_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b0;
            r_clr_cnt  <= '0;
        end else if (i_cmd.clr_start) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == (ADDR_W+1)'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_map[r_clr_cnt[ADDR_W-1:0]] <= 1'b0;
        end else if (i_cmd.wr_map) begin
            r_map[w_addr] <= r_wall_bit;
        end
        r_rd <= r_map[w_addr];
    end

    // Capture and stepping. The side distance sums grow by at most MOVES
    // adds of 31-bit steps, so they never wrap in SD_W bits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_dx    <= i_ray_dir_x;
            r_dy    <= i_ray_dir_y;
            r_sdx   <= SD_W'(i_side_dist_x);
            r_sdy   <= SD_W'(i_side_dist_y);
            r_ddx   <= i_delta_dist_x;
            r_ddy   <= i_delta_dist_y;
            r_cx    <= CW'({2'b00, i_pos_x[POS_W-1:FRAC_BITS]});
            r_cy    <= CW'({2'b00, i_pos_y[POS_W-1:FRAC_BITS]});
            r_wall_bit <= i_cell_wall;
            r_moves <= '0;
            r_side  <= 1'b0;
        end else if (i_cmd.step) begin
            r_moves <= r_moves + 1'b1;
            if (r_sdx < r_sdy) begin
                r_sdx  <= r_sdx + SD_W'(r_ddx);
                r_cx   <= w_ncx;
                r_side <= 1'b0;
            end else begin
                r_sdy  <= r_sdy + SD_W'(r_ddy);
                r_cy   <= w_ncy;
                r_side <= 1'b1;
            end
        end
    end
    assign w_ncx = r_dx[DIR_W-1] ? r_cx - CW'(1) : r_cx + CW'(1);
    assign w_ncy = r_dy[DIR_W-1] ? r_cy - CW'(1) : r_cy + CW'(1);

    assign o_stat.clr_busy  = r_clr_busy;
    assign o_stat.in_map    = !w_out;
    assign o_stat.wall      = r_rd;
    assign o_stat.step_done = (r_moves == MV_W'(MOVES));

    // Perpendicular distance numerator.
    logic signed [POS_W+2:0] w_num;
    logic                    w_neg;
    logic [POS_W+1:0]        w_unum;
    logic signed [DIR_W-1:0] w_den;
    logic [DIR_W-1:0]        w_uden;
    logic                    w_sgn_bad;

    always_comb begin
        if (!r_side) begin
            w_num = (POS_W+3)'(r_cx) * (POS_W+3)'(2**FRAC_BITS)
                  - (POS_W+3)'({1'b0, r_px})
                  + (r_dx[DIR_W-1] ? (POS_W+3)'(2**FRAC_BITS) : '0);
            w_den = r_dx;
        end else begin
            w_num = (POS_W+3)'(r_cy) * (POS_W+3)'(2**FRAC_BITS)
                  - (POS_W+3)'({1'b0, r_py})
                  + (r_dy[DIR_W-1] ? (POS_W+3)'(2**FRAC_BITS) : '0);
            w_den = r_dy;
        end
        w_neg     = w_num[POS_W+2];
        w_unum    = w_neg ? (POS_W+2)'(-w_num) : w_num[POS_W+1:0];
        w_uden    = w_den[DIR_W-1] ? DIR_W'(-w_den) : DIR_W'(w_den);
        w_sgn_bad = (w_num != 0) && (w_neg != w_den[DIR_W-1]);
    end

    // Shared divider: perpendicular, then column height.
    logic [DNUM_W-1:0] w_dnum;
    logic [DIST_W-1:0] w_dden;
    logic              w_dstart;
    logic              w_dbusy;
    logic [DNUM_W-1:0] w_quot;

    assign w_dstart = i_cmd.div_start | i_cmd.hgt_start;
    assign w_dnum = i_cmd.hgt_start
                  ? DNUM_W'({i_window_width, {FRAC_BITS{1'b0}}})
                  : DNUM_W'({w_unum, {FRAC_BITS{1'b0}}});
    assign w_dden = i_cmd.hgt_start ? r_perp : DIST_W'(w_uden);

    grdda_divider #(.NUM_W(DNUM_W), .DEN_W(DIST_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_busy  (w_dbusy),
        .o_quot  (w_quot)
    );
    assign o_stat.div_busy = w_dbusy;

    logic              r_perp_zero_den, r_perp_zero;
    logic signed [PROD_W:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_perp_zero_den <= (w_den == 0);
            r_perp_zero     <= (w_num == 0) || w_sgn_bad;
        end
        // perp result: taken when controller asks for multiply
        if (i_cmd.mul_start) begin
            r_perp <= r_perp_zero_den ? DIST_MAX :
                      r_perp_zero ? '0 :
                      (|w_quot[DNUM_W-1:DIST_W]) ? DIST_MAX : w_quot[DIST_W-1:0];
        end
        if (i_cmd.hgt_start) begin
            r_prod <= $signed({1'b0, r_perp}) *
                      (r_side ? r_dx : r_dy);
        end
    end

    // Hit coordinate: floor shift is arithmetic shift.
    logic signed [PROD_W:0]  w_fl;
    logic signed [PROD_W+1:0] w_coord;
    assign w_fl    = r_prod >>> FRAC_BITS;
    assign w_coord = (PROD_W+2)'(w_fl) +
                     (PROD_W+2)'({1'b0, (r_side ? r_px : r_py)});

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_nowall) begin
                o_hit_side      <= 1'b0;
                o_hit_col       <= '0;
                o_hit_row       <= '0;
                o_perp_dist     <= '0;
                o_hit_coord     <= '0;
                o_column_height <= '0;
            end else begin
                o_hit_side      <= r_side;
                o_hit_col       <= CELL_W'(r_cx);
                o_hit_row       <= CELL_W'(r_cy);
                o_perp_dist     <= r_perp;
                o_hit_coord     <= w_coord[PROD_W+1] ? '0 :
                                   (w_coord > (PROD_W+2)'({POS_W{1'b1}})) ? '1 :
                                   w_coord[POS_W-1:0];
                o_column_height <= (r_perp == 0) ? '1 :
                                   (|w_quot[DNUM_W-1:HEIGHT_W]) ? '1 :
                                   w_quot[HEIGHT_W-1:0];
            end
        end
    end
endmodule : grdda_datapath
`default_nettype wire

// ----- src/grdda_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// grdda_ctrl: sequencing state machine of the ray caster
// Runs the clearing sweep, map writes, the cell walk and the arithmetic.
// ----------------------------------------------------------------------------
module grdda_ctrl
    import grdda_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire logic i_func,
    output logic      o_valid,
    input  wire logic i_ready,
    input  wire t_stat i_stat,
    output t_cmd      o_cmd
);
    typedef enum logic [10:0] {
        S_RST   = 11'b00000000001,
        S_CLR   = 11'b00000000010,
        S_IDLE  = 11'b00000000100,
        S_WR    = 11'b00000001000,
        S_STEP  = 11'b00000010000,
        S_CHK   = 11'b00000100000,
        S_LOOK  = 11'b00001000000,
        S_DIV   = 11'b00010000000,
        S_MUL   = 11'b00100000000,
        S_HGT   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_oval, n_oval;
    logic   r_first, n_first;

    // Accept a beat in idle only when the result register is free.
    assign o_ready = (r_state == S_IDLE) && !r_oval;
    assign o_valid = r_oval;

    always_comb begin
        n_state = r_state;
        n_oval  = r_oval && !i_ready;
        n_first = r_first;
        o_cmd   = '0;
        case (r_state)
            S_RST: begin
                o_cmd.clr_start = 1'b1;
                n_state = S_CLR;
            end
            S_CLR: if (!i_stat.clr_busy) n_state = S_IDLE;
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.load = 1'b1;
                    n_first = 1'b1;
                    n_state = (i_func == FUNC_CAST) ? S_CHK : S_WR;
                end
            end
            S_WR: begin
                o_cmd.wr_map = i_stat.in_map;
                n_state = S_IDLE;
            end
            S_CHK: begin
                // viewer check on first pass, bound check after each move
                if (!i_stat.in_map) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_nowall = 1'b1;
                    n_state = S_DONE;
                end else if (r_first) begin
                    n_first = 1'b0;
                    n_state = S_STEP;
                end else begin
                    n_state = S_LOOK;
                end
            end
            S_STEP: begin
                if (i_stat.step_done) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_nowall = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_LOOK: begin
                if (i_stat.wall) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_DIV: if (!i_stat.div_busy) begin
                o_cmd.mul_start = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.hgt_start = 1'b1;
                n_state = S_HGT;
            end
            S_HGT: if (!i_stat.div_busy) begin
                o_cmd.out_load = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_oval = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_RST;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST;
            r_oval  <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
            r_first <= n_first;
        end
    end

    a_rdy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_one_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> !r_oval) else $error("result overwritten");
    a_load_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_valid && o_ready) else $error("load without beat");
endmodule : grdda_ctrl
`default_nettype wire

// ----- src/grid_ray_dda_caster_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// grid_ray_dda_caster_unit: DDA grid ray caster over a wall bit map
// Input channel (i_valid/o_ready) carries write beats (func 0) that set one
// map cell and cast beats (func 1) that trace one ray. Each cast gives one
// result beat on o_valid/i_ready; writes give none. One beat is worked at a
// time: a write passes through the write state; a cast makes cell moves
// (step, bound check, registered map read) up to 2*MAP_SIZE+2 moves, then
// two passes through the shared one-bit-per-cycle divider and one multiply
// state. After reset the map is swept to open cells, during which no beat
// is accepted; i_window_width_we is taken any time.
// A waiting result holds in the output register; a new beat is accepted
// only after that result is taken.
// ----------------------------------------------------------------------------
module grid_ray_dda_caster_unit
    import grdda_pkg::*;
#(
    parameter int MAP_SIZE  = DEF_MAP_SIZE,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_window_width_we,
    input  wire logic [WIDTH_W-1:0]      i_window_width,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic                    i_func,
    input  wire logic                    i_cell_wall,
    input  wire logic [POS_W-1:0]        i_pos_x,
    input  wire logic [POS_W-1:0]        i_pos_y,
    input  wire logic signed [DIR_W-1:0] i_ray_dir_x,
    input  wire logic signed [DIR_W-1:0] i_ray_dir_y,
    input  wire logic [DIST_W-1:0]       i_side_dist_x,
    input  wire logic [DIST_W-1:0]       i_side_dist_y,
    input  wire logic [DIST_W-1:0]       i_delta_dist_x,
    input  wire logic [DIST_W-1:0]       i_delta_dist_y,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic                         o_hit_side,
    output logic [CELL_W-1:0]            o_hit_col,
    output logic [CELL_W-1:0]            o_hit_row,
    output logic [DIST_W-1:0]            o_perp_dist,
    output logic [POS_W-1:0]             o_hit_coord,
    output logic [HEIGHT_W-1:0]          o_column_height,
    output logic                         o_no_wall
);
    logic [WIDTH_W-1:0] r_width;
    logic               r_nowall;
    t_cmd               w_cmd;
    t_stat              w_stat;

    // Hold the column height numerator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (i_window_width_we) begin
            r_width <= i_window_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_nowall <= w_cmd.out_nowall;
        end
    end
    assign o_no_wall = r_nowall;

    grdda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_func  (i_func),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    grdda_datapath #(.MAP_SIZE(MAP_SIZE), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_window_width  (r_width),
        .i_cell_wall     (i_cell_wall),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_ray_dir_x     (i_ray_dir_x),
        .i_ray_dir_y     (i_ray_dir_y),
        .i_side_dist_x   (i_side_dist_x),
        .i_side_dist_y   (i_side_dist_y),
        .i_delta_dist_x  (i_delta_dist_x),
        .i_delta_dist_y  (i_delta_dist_y),
        .o_hit_side      (o_hit_side),
        .o_hit_col       (o_hit_col),
        .o_hit_row       (o_hit_row),
        .o_perp_dist     (o_perp_dist),
        .o_hit_coord     (o_hit_coord),
        .o_column_height (o_column_height)
    );

    a_nowall_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_wall |-> o_perp_dist == '0 && o_column_height == '0)
        else $error("no-wall result carries data");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_perp_dist))
        else $error("result changed while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("accept while result waits");
endmodule : grid_ray_dda_caster_unit
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for grid_ray_dda_caster_unit
// Drives map writes and ray casts through the valid/ready input channel and
// checks each cast result against an in-bench DDA trace of the map or a
// hand-computed expectation; a directed table comes first. Random beats
// follow over several window widths, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import grdda_pkg::*;

    localparam int  MAP       = DEF_MAP_SIZE;
    localparam int  FB        = DEF_FRAC_BITS;
    localparam int  MAX_MOVES = 2 * MAP + 2;
    localparam int  WDOG_MAX  = 20000;   // idle cycles allowed between beats
    localparam int  SETTLE    = 600;     // final wait after the last beat
    localparam longint unsigned DIST_SAT  = 64'h7FFF_FFFF;
    localparam longint          COORD_SAT = 64'h3F_FFFF;
    localparam longint unsigned HGT_SAT   = 64'hFFFF;

    typedef struct packed {
        bit                    func;
        bit                    wall;
        bit [POS_W-1:0]        pos_x;
        bit [POS_W-1:0]        pos_y;
        bit signed [DIR_W-1:0] dir_x;
        bit signed [DIR_W-1:0] dir_y;
        bit [DIST_W-1:0]       sdx;
        bit [DIST_W-1:0]       sdy;
        bit [DIST_W-1:0]       ddx;
        bit [DIST_W-1:0]       ddy;
    } t_ray_beat;

    typedef struct packed {
        bit                  side;
        bit [CELL_W-1:0]     col;
        bit [CELL_W-1:0]     row;
        bit [DIST_W-1:0]     perp;
        bit [POS_W-1:0]      coord;
        bit [HEIGHT_W-1:0]   height;
        bit                  no_wall;
    } t_wall_hit;

    typedef struct {
        t_ray_beat beat;
        bit        typed;   // expectation written by hand below
        t_wall_hit hit;
    } t_table_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_window_width_we;
    logic [WIDTH_W-1:0]      i_window_width;
    logic                    i_valid;
    logic                    o_ready;
    logic                    i_func;
    logic                    i_cell_wall;
    logic [POS_W-1:0]        i_pos_x;
    logic [POS_W-1:0]        i_pos_y;
    logic signed [DIR_W-1:0] i_ray_dir_x;
    logic signed [DIR_W-1:0] i_ray_dir_y;
    logic [DIST_W-1:0]       i_side_dist_x;
    logic [DIST_W-1:0]       i_side_dist_y;
    logic [DIST_W-1:0]       i_delta_dist_x;
    logic [DIST_W-1:0]       i_delta_dist_y;
    logic                    o_valid;
    logic                    i_ready;
    logic                    o_hit_side;
    logic [CELL_W-1:0]       o_hit_col;
    logic [CELL_W-1:0]       o_hit_row;
    logic [DIST_W-1:0]       o_perp_dist;
    logic [POS_W-1:0]        o_hit_coord;
    logic [HEIGHT_W-1:0]     o_column_height;
    logic                    o_no_wall;

    grid_ray_dda_caster_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_window_width_we (i_window_width_we),
        .i_window_width    (i_window_width),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_func            (i_func),
        .i_cell_wall       (i_cell_wall),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_ray_dir_x       (i_ray_dir_x),
        .i_ray_dir_y       (i_ray_dir_y),
        .i_side_dist_x     (i_side_dist_x),
        .i_side_dist_y     (i_side_dist_y),
        .i_delta_dist_x    (i_delta_dist_x),
        .i_delta_dist_y    (i_delta_dist_y),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_hit_side        (o_hit_side),
        .o_hit_col         (o_hit_col),
        .o_hit_row         (o_hit_row),
        .o_perp_dist       (o_perp_dist),
        .o_hit_coord       (o_hit_coord),
        .o_column_height   (o_column_height),
        .o_no_wall         (o_no_wall)
    );

    // Shadow copy of the wall map and the width register.
    bit               wall_map [MAP*MAP];
    bit [WIDTH_W-1:0] shadow_width;

    t_wall_hit  pending_hits[$];
    t_table_row rows[$];
    int         errors;
    int         idle_cycles;
    bit         calm;          // no stalls on either side
    int         ready_hold;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Trace one beat through the shadow map. Return 1 when a result is due.
    function automatic bit trace_ray(input t_ray_beat b, output t_wall_hit r);
        longint cx, cy, sx, sy, sdx, sdy, dx, dy;
        longint num, den, prod, coord, other, scaled;
        longint unsigned perp, hgt, un, ud;
        bit hit, side;
        r    = '0;
        cx   = longint'(b.pos_x) >>> FB;
        cy   = longint'(b.pos_y) >>> FB;
        hit  = 1'b0;
        side = 1'b0;
        if (b.func == FUNC_WRITE) begin
            if (cx < MAP && cy < MAP) wall_map[cy * MAP + cx] = b.wall;
            return 1'b0;
        end
        dx  = b.dir_x;
        dy  = b.dir_y;
        sx  = dx < 0 ? -1 : 1;
        sy  = dy < 0 ? -1 : 1;
        sdx = longint'(b.sdx);
        sdy = longint'(b.sdy);
        // The start cell is never tested; a viewer off the map makes no move.
        if (cx < MAP && cy < MAP) begin
            for (int n = 0; n < MAX_MOVES; n++) begin
                if (sdx < sdy) begin
                    sdx += longint'(b.ddx);
                    cx += sx;
                    side = 1'b0;
                end else begin
                    sdy += longint'(b.ddy);
                    cy += sy;
                    side = 1'b1;
                end
                if (cx < 0 || cy < 0 || cx >= MAP || cy >= MAP) break;
                if (wall_map[cy * MAP + cx]) begin
                    hit = 1'b1;
                    break;
                end
            end
        end
        if (!hit) begin
            r.no_wall = 1'b1;
            return 1'b1;
        end
        if (side == 1'b0) begin
            num   = (cx << FB) - longint'(b.pos_x) + (((1 - sx) / 2) << FB);
            den   = dx;
            other = longint'(b.pos_y);
            prod  = dy;
        end else begin
            num   = (cy << FB) - longint'(b.pos_y) + (((1 - sy) / 2) << FB);
            den   = dy;
            other = longint'(b.pos_x);
            prod  = dx;
        end
        // Saturate on a zero divisor, clamp a negative quotient to zero.
        if (den == 0) perp = DIST_SAT;
        else if (num == 0 || ((num < 0) != (den < 0))) perp = 0;
        else begin
            un   = num < 0 ? -num : num;
            ud   = den < 0 ? -den : den;
            perp = (un << FB) / ud;
            if (perp > DIST_SAT) perp = DIST_SAT;
        end
        prod   = longint'(perp) * prod;
        scaled = prod >= 0 ? (prod >>> FB) : -((-prod + ((64'sd1 << FB) - 1)) >>> FB);
        coord  = other + scaled;
        if (coord < 0) coord = 0;
        if (coord > COORD_SAT) coord = COORD_SAT;
        if (perp == 0) hgt = HGT_SAT;
        else begin
            hgt = (longint'(shadow_width) << FB) / perp;
            if (hgt > HGT_SAT) hgt = HGT_SAT;
        end
        r.side   = side;
        r.col    = cx[CELL_W-1:0];
        r.row    = cy[CELL_W-1:0];
        r.perp   = perp[DIST_W-1:0];
        r.coord  = coord[POS_W-1:0];
        r.height = hgt[HEIGHT_W-1:0];
        return 1'b1;
    endfunction

    function automatic t_ray_beat map_write(int col, int row, bit wall);
        t_ray_beat b = '0;
        b.func  = FUNC_WRITE;
        b.wall  = wall;
        b.pos_x = POS_W'(col) << FB;
        b.pos_y = POS_W'(row) << FB;
        return b;
    endfunction

    function automatic t_ray_beat ray_cast(longint px, longint py, longint vx, longint vy,
                                           longint s_x, longint s_y, longint d_x, longint d_y);
        t_ray_beat b;
        b.func  = FUNC_CAST;
        b.wall  = 1'b0;
        b.pos_x = px[POS_W-1:0];
        b.pos_y = py[POS_W-1:0];
        b.dir_x = vx[DIR_W-1:0];
        b.dir_y = vy[DIR_W-1:0];
        b.sdx   = s_x[DIST_W-1:0];
        b.sdy   = s_y[DIST_W-1:0];
        b.ddx   = d_x[DIST_W-1:0];
        b.ddy   = d_y[DIST_W-1:0];
        return b;
    endfunction

    function automatic void add_row(t_ray_beat b, bit typed, t_wall_hit h);
        t_table_row t;
        t.beat  = b;
        t.typed = typed;
        t.hit   = h;
        rows.push_back(t);
    endfunction

    // Random beat: mostly casts and writes inside a small corner of the map so
    // that rays meet walls; a share of full-range fields for the odd cases.
    function automatic t_ray_beat random_beat();
        t_ray_beat b;
        int span;
        b.func  = ($urandom_range(0, 99) < 30) ? FUNC_WRITE : FUNC_CAST;
        b.wall  = ($urandom_range(0, 99) < 55);
        span    = ($urandom_range(0, 99) < 70) ? 15 : MAP - 1;
        b.pos_x = {POS_W'($urandom_range(0, span)) << FB} | POS_W'($urandom_range(0, 65535));
        b.pos_y = {POS_W'($urandom_range(0, span)) << FB} | POS_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 99) < 8) b.pos_x = POS_W'($urandom);
        if ($urandom_range(0, 99) < 8) b.pos_y = POS_W'($urandom);
        b.dir_x = DIR_W'(int'($urandom_range(0, 262144)) - 131072);
        b.dir_y = DIR_W'(int'($urandom_range(0, 262144)) - 131072);
        if ($urandom_range(0, 99) < 5) b.dir_x = '0;
        if ($urandom_range(0, 99) < 5) b.dir_y = '0;
        if ($urandom_range(0, 99) < 85) begin
            b.sdx = DIST_W'($urandom_range(0, 2 << FB));
            b.sdy = DIST_W'($urandom_range(0, 2 << FB));
            b.ddx = DIST_W'($urandom_range(0, 4 << FB));
            b.ddy = DIST_W'($urandom_range(0, 4 << FB));
        end else begin
            b.sdx = DIST_W'($urandom);
            b.sdy = DIST_W'($urandom);
            b.ddx = DIST_W'($urandom);
            b.ddy = DIST_W'($urandom);
        end
        return b;
    endfunction

    // Present one beat; return at the edge that accepts it and record the
    // expectation. The caller is at a rising edge when this starts.
    task automatic send_beat(input t_ray_beat b, input bit typed, input t_wall_hit h);
        t_wall_hit r;
        i_valid        <= 1'b1;
        i_func         <= b.func;
        i_cell_wall    <= b.wall;
        i_pos_x        <= b.pos_x;
        i_pos_y        <= b.pos_y;
        i_ray_dir_x    <= b.dir_x;
        i_ray_dir_y    <= b.dir_y;
        i_side_dist_x  <= b.sdx;
        i_side_dist_y  <= b.sdy;
        i_delta_dist_x <= b.ddx;
        i_delta_dist_y <= b.ddy;
        do @(posedge i_clk); while (!o_ready);
        if (trace_ray(b, r)) pending_hits.push_back(typed ? h : r);
    endtask

    // Drop valid for a random burst now and then.
    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every result is back and the block is quiet.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_width(input bit [WIDTH_W-1:0] w);
        i_window_width_we <= 1'b1;
        i_window_width    <= w;
        @(posedge i_clk);
        i_window_width_we <= 1'b0;
        shadow_width = w;
    endtask

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %0d actual %0d", name, exp_v, act_v);
        end
    endfunction

    // Result side: random ready stalls, check each accepted result beat.
    always @(posedge i_clk) begin
        t_wall_hit e;
        if (calm) begin
            i_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            i_ready    <= ($urandom_range(0, 3) != 0);
            ready_hold <= $urandom_range(0, 11);
        end
        if (o_valid && i_ready) begin
            if (pending_hits.size() == 0) begin
                errors++;
                if (errors <= 10) $display("mismatch: result beat with nothing expected");
            end else begin
                e = pending_hits.pop_front();
                check_field("hit_side", e.side, o_hit_side);
                check_field("hit_col", e.col, o_hit_col);
                check_field("hit_row", e.row, o_hit_row);
                check_field("perp_dist", e.perp, o_perp_dist);
                check_field("hit_coord", e.coord, o_hit_coord);
                check_field("column_height", e.height, o_column_height);
                check_field("no_wall", e.no_wall, o_no_wall);
            end
        end
    end

    // Watchdog: count edges with no beat moving on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_wall_hit           h;
        bit [WIDTH_W-1:0]    widths[4];
        longint              half;
        half              = 64'd1 << (FB - 1);
        errors            = 0;
        idle_cycles       = 0;
        calm              = 1'b0;
        ready_hold        = 0;
        shadow_width      = WIDTH_RESET;
        foreach (wall_map[k]) wall_map[k] = 1'b0;
        i_rst_n           <= 1'b0;
        i_window_width_we <= 1'b0;
        i_window_width    <= '0;
        i_valid           <= 1'b0;
        i_ready           <= 1'b0;
        i_func            <= FUNC_WRITE;
        i_cell_wall       <= 1'b0;
        i_pos_x           <= '0;
        i_pos_y           <= '0;
        i_ray_dir_x       <= '0;
        i_ray_dir_y       <= '0;
        i_side_dist_x     <= '0;
        i_side_dist_y     <= '0;
        i_delta_dist_x    <= '0;
        i_delta_dist_y    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Viewer mostly at (10.5, 10.5); walls go at
        // (12,10), (8,10) and (10,12).
        h = '0;
        h.no_wall = 1'b1;
        // Empty map after reset: the ray runs off the edge.
        add_row(ray_cast(10 * 65536 + half, 10 * 65536 + half, 65536, 0,
                         half, DIST_SAT, 65536, DIST_SAT), 1, h);
        // Column 64 wraps to 0 in the position field: viewer at the left
        // edge walks diagonally off the empty map.
        add_row(ray_cast(64 * 65536, 3 * 65536, 65536, 65536, 0, 0, 65536, 65536), 1, h);
        add_row(ray_cast(COORD_SAT, COORD_SAT, -131072, -131072,
                         DIST_SAT, DIST_SAT, DIST_SAT, DIST_SAT), 1, h);
        // Column 64 wraps to 0 here too: this marks the corner cell.
        add_row(map_write(MAP, 0, 1), 0, h);
        add_row(map_write(12, 10, 1), 0, h);
        add_row(map_write(8, 10, 1), 0, h);
        add_row(map_write(10, 12, 1), 0, h);
        // Positive x: crosses 11 then hits 12; perp 1.5, height 640/1.5.
        h = '{side: 0, col: 12, row: 10, perp: 98304, coord: 688128, height: 426, no_wall: 0};
        add_row(ray_cast(10 * 65536 + half, 10 * 65536 + half, 65536, 0,
                         half, DIST_SAT, 65536, DIST_SAT), 1, h);
        // Negative x: same distance to the wall at column 8.
        h.col = 8;
        add_row(ray_cast(10 * 65536 + half, 10 * 65536 + half, -65536, 0,
                         half, DIST_SAT, 65536, DIST_SAT), 1, h);
        // Zero component on the hit axis: distance saturates, the coordinate
        // clamps high, height 0.
        h = '{side: 0, col: 12, row: 10, perp: DIST_W'(DIST_SAT), coord: POS_W'(COORD_SAT),
              height: 0, no_wall: 0};
        add_row(ray_cast(10 * 65536 + half, 10 * 65536 + half, 0, 65536,
                         half, DIST_SAT, 65536, DIST_SAT), 1, h);
        // Zero distance from an integer start: height saturates.
        h = '{side: 0, col: 8, row: 10, perp: 0, coord: 688128, height: HEIGHT_W'(HGT_SAT),
              no_wall: 0};
        add_row(ray_cast(9 * 65536, 10 * 65536 + half, -65536, 0,
                         0, DIST_SAT, 65536, DIST_SAT), 1, h);
        // Positive y onto the wall at row 12.
        h = '{side: 1, col: 10, row: 12, perp: 98304, coord: 688128, height: 426, no_wall: 0};
        add_row(ray_cast(10 * 65536 + half, 10 * 65536 + half, 0, 65536,
                         DIST_SAT, half, DIST_SAT, 65536), 1, h);
        // Diagonal and extreme directions, checked by the trace.
        add_row(ray_cast(10 * 65536 + half, 10 * 65536 + half, 131072, -131072,
                         half, 0, 32768, 32768), 0, h);
        add_row(ray_cast(11 * 65536 + 1000, 9 * 65536 + 60000, -131072, 131072,
                         40000, 5000, 90000, 70000), 0, h);
        add_row(ray_cast(63 * 65536 + 65535, 0, 65536, -65536, 0, 0, 65536, 65536), 0, h);
        // Clear a wall; the +x ray then leaves the map.
        add_row(map_write(12, 10, 0), 0, h);
        h = '0;
        h.no_wall = 1'b1;
        add_row(ray_cast(10 * 65536 + half, 10 * 65536 + half, 65536, 0,
                         half, DIST_SAT, 65536, DIST_SAT), 1, h);

        // Block refuses beats during its clearing sweep; send_beat waits.
        @(posedge i_clk);
        foreach (rows[k]) begin
            maybe_gap();
            send_beat(rows[k].beat, rows[k].typed, rows[k].hit);
        end
        drain();

        // Random part across several widths, the minimum of 1 included.
        widths[0] = 13'd1;
        widths[1] = 13'd4096;
        widths[2] = 13'd4095;
        widths[3] = WIDTH_W'($urandom_range(1, 4096));
        for (int ph = 0; ph < 4; ph++) begin
            write_width(widths[ph]);
            for (int k = 0; k < 275; k++) begin
                // Keep the tail of the run free of stalls.
                if (ph == 3 && k == 125) calm = 1'b1;
                maybe_gap();
                send_beat(random_beat(), 0, h);
            end
            drain();
        end

        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && pending_hits.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
